FILE: rtl/assert_macros.svh
// Assertion macros shared by the splitter RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/csvfs_pkg.sv
// Types, codes and helper functions of the CSV field splitter.
// No dependencies; every RTL source but assert_macros.svh imports this package.
package csvfs_pkg;

  // Sizes.
  localparam int MAX_COLS = 64;
  localparam int COL_W    = 6;
  localparam int CNT_W    = 7;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EOL   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_LINE    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CLS_EMPTY = 2'd0,
    CLS_INT   = 2'd1,
    CLS_REAL  = 2'd2,
    CLS_TEXT  = 2'd3
  } cls_t;

  // Parser position within a line.
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_UNQ   = 3'd1,
    MODE_INQ   = 3'd2,
    MODE_QPEND = 3'd3,
    MODE_SKIP  = 3'd4
  } mode_t;

  // Running classification of the field seen so far.
  typedef enum logic [2:0] {
    TRK_EMPTY = 3'd0,
    TRK_MINUS = 3'd1,
    TRK_INT   = 3'd2,
    TRK_REAL  = 3'd3,
    TRK_TEXT  = 3'd4
  } trk_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [COL_W-1:0] field_index;
    cls_t             field_class;
    cls_t             column_class;
    logic [CNT_W-1:0] field_count;
  } result_t;

  // One input item's results: one, or two when two is set.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  // Write side of the queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // Read side of the queue.
  typedef struct packed {
    logic   empty;
    entry_t head;
  } head_t;

  function automatic trk_t track(trk_t t, logic [7:0] b);
    logic dig;
    trk_t n;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    unique case (t)
      TRK_EMPTY: begin
        if (b == CH_MINUS) n = TRK_MINUS;
        else if (dig) n = TRK_INT;
        else if (b == CH_DOT) n = TRK_REAL;
        else n = TRK_TEXT;
      end
      TRK_MINUS, TRK_INT: begin
        if (dig) n = TRK_INT;
        else if (b == CH_DOT) n = TRK_REAL;
        else n = TRK_TEXT;
      end
      TRK_REAL: begin
        n = dig ? TRK_REAL : TRK_TEXT;
      end
      default: begin
        n = TRK_TEXT;
      end
    endcase
    return n;
  endfunction

  function automatic cls_t final_class(trk_t t);
    cls_t c;
    unique case (t)
      TRK_EMPTY: c = CLS_EMPTY;
      TRK_INT:   c = CLS_INT;
      TRK_REAL:  c = CLS_REAL;
      default:   c = CLS_TEXT;
    endcase
    return c;
  endfunction

  function automatic cls_t cls_max(cls_t a, cls_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic result_t mk_content(logic [COL_W-1:0] idx, logic [7:0] b);
    result_t r;
    r = '0;
    r.kind        = KIND_CONTENT;
    r.data_byte   = b;
    r.field_index = idx;
    return r;
  endfunction

  function automatic result_t mk_field_end(logic [COL_W-1:0] idx, cls_t fc);
    result_t r;
    r = '0;
    r.kind        = KIND_FIELD;
    r.field_index = idx;
    r.field_class = fc;
    return r;
  endfunction

  function automatic result_t mk_line_end(logic [CNT_W-1:0] cnt);
    result_t r;
    r = '0;
    r.kind        = KIND_LINE;
    r.field_count = cnt;
    return r;
  endfunction

endpackage

FILE: rtl/csvfs_intf.sv
// Handshake interfaces of the splitter: the byte/command input and the result output.
// Depends on csvfs_pkg for field widths.
interface csvfs_in_if;
  import csvfs_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink (input valid, input cmd, input ch, output ready);
endinterface

interface csvfs_out_if;
  import csvfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       data_byte;
  logic [COL_W-1:0] field_index;
  logic [1:0]       field_class;
  logic [1:0]       column_class;
  logic [CNT_W-1:0] field_count;
  logic             last;

  modport source (
    output valid, output kind, output data_byte, output field_index,
    output field_class, output column_class, output field_count, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input field_index,
    input field_class, input column_class, input field_count, input last,
    output ready
  );
endinterface

FILE: rtl/csvfs_front.sv
// Front end: accepts items, runs the line parser and classifier, and keeps the
// column type table. Depends on csvfs_pkg and csvfs_intf.
module csvfs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  csvfs_in_if.sink                      in_ch,
  input  logic                          cfg_we,
  input  logic [csvfs_pkg::CNT_W-1:0]   cfg_data,
  input  logic                          q_full,
  output csvfs_pkg::push_t              q_wr
);
  import csvfs_pkg::*;

  // Parser state.
  logic [CNT_W-1:0] max_fields_r;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  trk_t             trk_r, trk_nxt;

  // Table stage: one parsed item waiting for its column lookup.
  logic             p_valid_r;
  logic             p_any_r;
  logic             p_fe_r;
  logic             p_clear_r;
  entry_t           p_entry_r;
  logic             byp_r;
  cls_t             byp_val_r;
  logic             vld_q_r;
  cls_t             mem_q_r;

  // Column type table with per-entry valid bits.
  cls_t              col_mem [MAX_COLS];
  logic [MAX_COLS-1:0] col_vld_r;

  logic             accept;
  logic             p_go;
  logic             eol;
  logic             is_quote;
  logic             is_comma;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cur_inc;
  logic             at_lim;
  logic             inc_at_lim;
  logic [COL_W-1:0] rd_idx;
  logic             any_nxt, two_nxt, fe_nxt, clr_nxt;
  result_t          r0_nxt, r1_nxt;
  cls_t             old_cls;
  cls_t             p_cc;
  entry_t           out_entry;

  // Shared decode of the current byte and field limit.
  assign eol        = (in_ch.cmd == CMD_EOL) || (in_ch.ch == CH_NUL) ||
                      (in_ch.ch == CH_LF) || (in_ch.ch == CH_CR);
  assign is_quote   = (in_ch.ch == CH_QUOTE);
  assign is_comma   = (in_ch.ch == CH_COMMA);
  assign lim        = (max_fields_r > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : max_fields_r;
  assign cur_inc    = cur_r + CNT_W'(1);
  assign at_lim     = (cur_r >= lim);
  assign inc_at_lim = (cur_inc >= lim);
  assign rd_idx     = cur_r[COL_W-1:0];

  // The table stage drains when its item has no results or the queue has room.
  assign p_go        = p_valid_r && (!p_any_r || !q_full);
  assign in_ch.ready = !p_valid_r || p_go;
  assign accept      = in_ch.valid && in_ch.ready;

  // Next parser mode.
  always_comb begin
    mode_nxt = mode_r;
    priority if ((in_ch.cmd == CMD_CLEAR) || (in_ch.cmd == CMD_NOP)) begin
      mode_nxt = mode_r;
    end else if (eol) begin
      mode_nxt = MODE_START;
    end else begin
      unique case (mode_r)
        MODE_START: begin
          if (at_lim) mode_nxt = MODE_SKIP;
          else if (is_quote) mode_nxt = MODE_INQ;
          else if (is_comma) mode_nxt = inc_at_lim ? MODE_SKIP : MODE_START;
          else mode_nxt = MODE_UNQ;
        end
        MODE_UNQ: begin
          if (is_comma) mode_nxt = inc_at_lim ? MODE_SKIP : MODE_START;
        end
        MODE_INQ: begin
          if (is_quote) mode_nxt = MODE_QPEND;
        end
        MODE_QPEND: begin
          if (is_comma) mode_nxt = inc_at_lim ? MODE_SKIP : MODE_START;
          else mode_nxt = MODE_INQ;
        end
        default: begin
          mode_nxt = MODE_SKIP;
        end
      endcase
    end
  end

  // Results, field counter and classifier update of one item.
  always_comb begin
    any_nxt = 1'b0;
    two_nxt = 1'b0;
    fe_nxt  = 1'b0;
    clr_nxt = 1'b0;
    r0_nxt  = '0;
    r1_nxt  = '0;
    cur_nxt = cur_r;
    trk_nxt = trk_r;
    priority if (in_ch.cmd == CMD_CLEAR) begin
      clr_nxt = 1'b1;
    end else if (in_ch.cmd == CMD_NOP) begin
      any_nxt = 1'b0;
    end else if (eol) begin
      any_nxt = 1'b1;
      if ((mode_r == MODE_UNQ) || (mode_r == MODE_INQ) || (mode_r == MODE_QPEND)) begin
        two_nxt = 1'b1;
        fe_nxt  = 1'b1;
        r0_nxt  = mk_field_end(rd_idx, final_class(trk_r));
        r1_nxt  = mk_line_end(cur_inc);
      end else begin
        r0_nxt = mk_line_end(cur_r);
      end
      cur_nxt = '0;
      trk_nxt = TRK_EMPTY;
    end else begin
      unique case (mode_r)
        MODE_START: begin
          trk_nxt = TRK_EMPTY;
          if (at_lim || is_quote) begin
            any_nxt = 1'b0;
          end else if (is_comma) begin
            any_nxt = 1'b1;
            fe_nxt  = 1'b1;
            r0_nxt  = mk_field_end(rd_idx, CLS_EMPTY);
            cur_nxt = cur_inc;
          end else begin
            any_nxt = 1'b1;
            r0_nxt  = mk_content(rd_idx, in_ch.ch);
            trk_nxt = track(TRK_EMPTY, in_ch.ch);
          end
        end
        MODE_UNQ: begin
          any_nxt = 1'b1;
          if (is_comma) begin
            fe_nxt  = 1'b1;
            r0_nxt  = mk_field_end(rd_idx, final_class(trk_r));
            cur_nxt = cur_inc;
            trk_nxt = TRK_EMPTY;
          end else begin
            r0_nxt  = mk_content(rd_idx, in_ch.ch);
            trk_nxt = track(trk_r, in_ch.ch);
          end
        end
        MODE_INQ: begin
          if (!is_quote) begin
            any_nxt = 1'b1;
            r0_nxt  = mk_content(rd_idx, in_ch.ch);
            trk_nxt = track(trk_r, in_ch.ch);
          end
        end
        MODE_QPEND: begin
          any_nxt = 1'b1;
          if (is_comma) begin
            fe_nxt  = 1'b1;
            r0_nxt  = mk_field_end(rd_idx, final_class(trk_r));
            cur_nxt = cur_inc;
            trk_nxt = TRK_EMPTY;
          end else begin
            // The held quote turns out to be content, followed by this byte.
            two_nxt = 1'b1;
            r0_nxt  = mk_content(rd_idx, CH_QUOTE);
            r1_nxt  = mk_content(rd_idx, in_ch.ch);
            trk_nxt = track(track(trk_r, CH_QUOTE), in_ch.ch);
          end
        end
        default: begin
          any_nxt = 1'b0;
        end
      endcase
    end
  end

  // Parser registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r <= CNT_W'(MAX_COLS);
      mode_r       <= MODE_START;
      cur_r        <= '0;
      trk_r        <= TRK_EMPTY;
    end else begin
      if (cfg_we) max_fields_r <= cfg_data;
      if (accept) begin
        mode_r <= mode_nxt;
        cur_r  <= cur_nxt;
        trk_r  <= trk_nxt;
      end
    end
  end

  // Table stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (accept) begin
      p_valid_r <= 1'b1;
    end else if (p_go) begin
      p_valid_r <= 1'b0;
    end
  end

  // Table stage payload. The draining item is the only table write still ahead of
  // the new item, so its write is forwarded here.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_any_r           <= any_nxt;
      p_fe_r            <= fe_nxt;
      p_clear_r         <= clr_nxt;
      p_entry_r.two     <= two_nxt;
      p_entry_r.res0    <= r0_nxt;
      p_entry_r.res1    <= r1_nxt;
      byp_r             <= p_go && (p_clear_r ||
                           (p_fe_r && (p_entry_r.res0.field_index == rd_idx)));
      byp_val_r         <= p_clear_r ? CLS_EMPTY : p_cc;
      vld_q_r           <= col_vld_r[rd_idx];
    end
  end

  // Column table memory: registered read at accept, write when a field end drains.
  always_ff @(posedge clk) begin
    if (accept) mem_q_r <= col_mem[rd_idx];
    if (p_go && p_fe_r) col_mem[p_entry_r.res0.field_index] <= p_cc;
  end

  // Valid bits; a clear empties the whole table at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (p_go && p_clear_r) begin
      col_vld_r <= '0;
    end else if (p_go && p_fe_r) begin
      col_vld_r[p_entry_r.res0.field_index] <= 1'b1;
    end
  end

  // Widen the column class with this field's class.
  assign old_cls = byp_r ? byp_val_r : (vld_q_r ? mem_q_r : CLS_EMPTY);
  assign p_cc    = cls_max(p_entry_r.res0.field_class, old_cls);

  always_comb begin
    out_entry = p_entry_r;
    if (p_fe_r) out_entry.res0.column_class = p_cc;
  end

  assign q_wr.push  = p_go && p_any_r;
  assign q_wr.entry = out_entry;

endmodule

FILE: rtl/csvfs_queue.sv
// Short queue of parsed items between the front end and the output stage.
// Depends on csvfs_pkg.
module csvfs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  csvfs_pkg::push_t  q_wr,
  output logic              q_full,
  input  logic              q_pop,
  output csvfs_pkg::head_t  q_rd
);
  import csvfs_pkg::*;

  entry_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign q_full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_rd.empty = (count_r == '0);
  assign q_rd.head  = q_mem[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && !q_rd.empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= q_wr.entry;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/csvfs_back.sv
// Output stage: splits queued items into single results in an output register.
// Depends on csvfs_pkg and csvfs_intf.
module csvfs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  csvfs_pkg::head_t  q_rd,
  output logic              q_pop,
  csvfs_out_if.source       out_ch
);
  import csvfs_pkg::*;

  result_t out_res_r;
  logic    out_last_r;
  logic    out_valid_r;
  logic    sel_r;
  logic    load;
  logic    is_last;
  result_t pick;

  // Take the next result whenever the register is free or being emptied.
  assign load    = !q_rd.empty && (!out_valid_r || out_ch.ready);
  assign pick    = sel_r ? q_rd.head.res1 : q_rd.head.res0;
  assign is_last = !q_rd.head.two || sel_r;
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sel_r       <= !is_last;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= pick;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.data_byte    = out_res_r.data_byte;
  assign out_ch.field_index  = out_res_r.field_index;
  assign out_ch.field_class  = out_res_r.field_class;
  assign out_ch.column_class = out_res_r.column_class;
  assign out_ch.field_count  = out_res_r.field_count;
  assign out_ch.last         = out_last_r;

endmodule

FILE: rtl/csv_field_splitter_type_classifier_core.sv
// Top level of the CSV field splitter and type classifier.
// Depends on csvfs_pkg, csvfs_intf, csvfs_front, csvfs_queue, csvfs_back, assert_macros.svh.
//
//   Port     Direction  Carries
//   in_ch    sink       cmd, ch            (valid/ready)
//   out_ch   source     one result word    (valid/ready)
//   cfg_*    input      max_fields write   (cfg_we, cfg_data)
//
// One input word is taken per cycle while the queue has room; a word yielding two results
// holds the output register for both, so the output register sets the rate at one result
// per cycle while out_ch is ready. Path of a result: table stage, queue, output register.
// Reset is synchronous; the column table valid bits clear at once, no sweep.
// A four-entry queue lets the input keep flowing while the output is stalled.
module csv_field_splitter_type_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  csvfs_in_if.sink                    in_ch,
  csvfs_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [csvfs_pkg::CNT_W-1:0] cfg_data
);
  import csvfs_pkg::*;
  `include "assert_macros.svh"

  push_t q_wr;
  head_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Parser and column table.
  csvfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // Decoupling queue.
  csvfs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // Result serializer.
  csvfs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // The front end must never push into a full queue.
  `ASSERT_NEVER(a_no_overflow, clk, rst_n, q_wr.push && q_full)
  // A line end is always the final result of its word.
  `ASSERT_IMPLY(a_line_last, clk, rst_n, out_ch.valid && (out_ch.kind == KIND_LINE), out_ch.last)
  // The widened column class never falls below the field's own class.
  `ASSERT_IMPLY(a_col_wide, clk, rst_n, out_ch.valid && (out_ch.kind == KIND_FIELD), out_ch.column_class >= out_ch.field_class)

endmodule

FILE: test/tb_top.sv
// Self-checking bench for csv_field_splitter_type_classifier_core.
// Uses csvfs_pkg types and the csvfs_in_if / csvfs_out_if handshake interfaces.
// Words are split and classed by a local line parser, then matched in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csvfs_pkg::*;

  // One result word as the splitter should produce it.
  typedef struct {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [COL_W-1:0] field_index;
    cls_t             field_class;
    cls_t             column_class;
    logic [CNT_W-1:0] field_count;
    logic             last;
  } split_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  csvfs_in_if  in_if ();
  csvfs_out_if out_if ();

  csv_field_splitter_type_classifier_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Line parser state, mirrored from the block.
  mode_t            parse_st = MODE_START;
  int unsigned      col_no = 0;
  trk_t             field_trk = TRK_EMPTY;
  cls_t             col_widest [MAX_COLS];
  logic [CNT_W-1:0] limit_reg = 7'd64;

  split_word_t split_words [$];

  int unsigned src_idle_pct = 25;
  int unsigned sink_idle_pct = 78;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned lines_checked = 0;
  int unsigned limit_writes = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Running class of a field after one more content byte.
  function automatic trk_t next_trk(trk_t t, logic [7:0] b);
    logic is_dig;
    is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    if (t == TRK_REAL) return is_dig ? TRK_REAL : TRK_TEXT;
    if (t == TRK_TEXT) return TRK_TEXT;
    if (is_dig) return TRK_INT;
    if (b == CH_DOT) return TRK_REAL;
    if (b == CH_MINUS && t == TRK_EMPTY) return TRK_MINUS;
    return TRK_TEXT;
  endfunction

  function automatic cls_t class_of(trk_t t);
    case (t)
      TRK_EMPTY: return CLS_EMPTY;
      TRK_INT:   return CLS_INT;
      TRK_REAL:  return CLS_REAL;
      default:   return CLS_TEXT;
    endcase
  endfunction

  function automatic void push_word(kind_t k, logic [7:0] b, int unsigned idx, cls_t fc,
                                    cls_t cc, int unsigned cnt);
    split_word_t w;
    w.kind         = k;
    w.data_byte    = b;
    w.field_index  = COL_W'(idx);
    w.field_class  = fc;
    w.column_class = cc;
    w.field_count  = CNT_W'(cnt);
    w.last         = 1'b0;
    split_words.push_back(w);
  endfunction

  function automatic void emit_content(logic [7:0] b);
    field_trk = next_trk(field_trk, b);
    push_word(KIND_CONTENT, b, col_no, CLS_EMPTY, CLS_EMPTY, 0);
  endfunction

  // Close the current field and widen its column.
  function automatic void close_field();
    cls_t fc;
    cls_t cc;
    fc = class_of(field_trk);
    cc = fc;
    if (col_no < MAX_COLS) begin
      if (col_widest[col_no] > cc) cc = col_widest[col_no];
      col_widest[col_no] = cc;
    end
    push_word(KIND_FIELD, 8'h00, col_no, fc, cc, 0);
    col_no++;
    field_trk = TRK_EMPTY;
  endfunction

  function automatic void after_comma();
    int unsigned lim;
    lim = (limit_reg > MAX_COLS) ? MAX_COLS : limit_reg;
    parse_st = (col_no >= lim) ? MODE_SKIP : MODE_START;
  endfunction

  // Work out the result words that one accepted input word causes.
  function automatic void split_item(cmd_e_t c, logic [7:0] b);
    int unsigned n0;
    int unsigned lim;
    split_word_t w;
    n0 = split_words.size();
    lim = (limit_reg > MAX_COLS) ? MAX_COLS : limit_reg;
    if (c == CMD_CLEAR) begin
      foreach (col_widest[i]) col_widest[i] = CLS_EMPTY;
    end else if (c == CMD_EOL ||
                 (c == CMD_BYTE && (b == CH_NUL || b == CH_LF || b == CH_CR))) begin
      if (parse_st inside {MODE_UNQ, MODE_INQ, MODE_QPEND}) close_field();
      push_word(KIND_LINE, 8'h00, 0, CLS_EMPTY, CLS_EMPTY, col_no);
      parse_st  = MODE_START;
      col_no    = 0;
      field_trk = TRK_EMPTY;
    end else if (c == CMD_BYTE) begin
      case (parse_st)
        MODE_START: begin
          field_trk = TRK_EMPTY;
          if (col_no >= lim) begin
            parse_st = MODE_SKIP;
          end else if (b == CH_QUOTE) begin
            parse_st = MODE_INQ;
          end else if (b == CH_COMMA) begin
            close_field();
            after_comma();
          end else begin
            emit_content(b);
            parse_st = MODE_UNQ;
          end
        end
        MODE_UNQ: begin
          if (b == CH_COMMA) begin
            close_field();
            after_comma();
          end else begin
            emit_content(b);
          end
        end
        MODE_INQ: begin
          if (b == CH_QUOTE) parse_st = MODE_QPEND;
          else emit_content(b);
        end
        MODE_QPEND: begin
          // A quote not followed by a comma or line end is plain content.
          if (b == CH_COMMA) begin
            close_field();
            after_comma();
          end else begin
            emit_content(CH_QUOTE);
            emit_content(b);
            parse_st = MODE_INQ;
          end
        end
        default: begin
          parse_st = MODE_SKIP;
        end
      endcase
    end
    if (split_words.size() > n0) begin
      w = split_words.pop_back();
      w.last = 1'b1;
      split_words.push_back(w);
    end
  endfunction

  function automatic void match_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endfunction

  // Compare one result word with the oldest outstanding word.
  function automatic void check_word();
    split_word_t w;
    if (split_words.size() == 0) begin
      fail_count++;
      $display("%0t ns: result word with none outstanding, expected none, actual kind %0h",
               $time, out_if.kind);
      return;
    end
    w = split_words.pop_front();
    words_checked++;
    if (w.kind == KIND_LINE) lines_checked++;
    match_field("kind", 8'(w.kind), 8'(out_if.kind));
    match_field("data_byte", w.data_byte, out_if.data_byte);
    match_field("field_index", 8'(w.field_index), 8'(out_if.field_index));
    match_field("field_class", 8'(w.field_class), 8'(out_if.field_class));
    match_field("column_class", 8'(w.column_class), 8'(out_if.column_class));
    match_field("field_count", 8'(w.field_count), 8'(out_if.field_count));
    match_field("last", 8'(w.last), 8'(out_if.last));
  endfunction

  // Receiver: random stalls on ready.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) limit_reg = cfg_data;
      if (in_if.valid && in_if.ready) split_item(cmd_e_t'(in_if.cmd), in_if.ch);
      if (out_if.valid && out_if.ready) check_word();
    end
  end

  // Send one input word, with random idle cycles ahead of it.
  task automatic send_word(cmd_e_t c, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= c;
    in_if.ch    <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_word(CMD_BYTE, s[i]);
  endtask

  // Let the block go quiet before touching the field limit.
  task automatic write_limit(logic [CNT_W-1:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (split_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [7:0] digit_byte();
    return 8'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(33, 126));
    while (b == CH_COMMA || b == CH_QUOTE) b = 8'($urandom_range(33, 126));
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    case ($urandom_range(4))
      0:       return CH_QUOTE;
      1:       return CH_COMMA;
      2:       return digit_byte();
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_limit();
    case ($urandom_range(3))
      0:       return CNT_W'($urandom_range(1, 4));
      1:       return CNT_W'($urandom_range(5, 63));
      2:       return CNT_W'(MAX_COLS);
      default: return CNT_W'($urandom_range(65, 127));
    endcase
  endfunction

  // One field of random shape: empty, numbers, text, quoted, lone signs or noise.
  task automatic send_random_field();
    case ($urandom_range(11))
      0: begin
      end
      1, 2, 3: begin
        if ($urandom_range(2) == 0) send_word(CMD_BYTE, CH_MINUS);
        repeat ($urandom_range(1, 4)) send_word(CMD_BYTE, digit_byte());
      end
      4, 5: begin
        if ($urandom_range(2) == 0) send_word(CMD_BYTE, CH_MINUS);
        repeat ($urandom_range(0, 3)) send_word(CMD_BYTE, digit_byte());
        send_word(CMD_BYTE, CH_DOT);
        repeat ($urandom_range(0, 3)) send_word(CMD_BYTE, digit_byte());
        if ($urandom_range(5) == 0) send_word(CMD_BYTE, CH_DOT);
      end
      6: begin
        repeat ($urandom_range(1, 4)) send_word(CMD_BYTE, text_byte());
      end
      7, 8: begin
        send_word(CMD_BYTE, CH_QUOTE);
        repeat ($urandom_range(0, 5)) send_word(CMD_BYTE, quoted_byte());
        if ($urandom_range(9) != 0) send_word(CMD_BYTE, CH_QUOTE);
      end
      9: begin
        case ($urandom_range(2))
          0:       send_text("-");
          1:       send_text(".");
          default: send_text("-.");
        endcase
      end
      10: begin
        repeat ($urandom_range(1, 3)) send_word(CMD_BYTE, 8'($urandom_range(255)));
      end
      default: begin
        send_word(CMD_BYTE, digit_byte());
        send_word(CMD_BYTE, text_byte());
      end
    endcase
  endtask

  // A whole line: mostly short, now and then wider than the column table.
  task automatic send_random_line();
    int unsigned nf;
    if ($urandom_range(14) == 0) send_word(cmd_e_t'($urandom_range(2, 3)), 8'($urandom));
    nf = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
    for (int i = 0; i < nf; i++) begin
      if (i != 0) send_word(CMD_BYTE, CH_COMMA);
      send_random_field();
    end
    case ($urandom_range(5))
      0: send_word(CMD_EOL, 8'($urandom));
      1: begin
        send_word(CMD_BYTE, CH_CR);
        send_word(CMD_BYTE, CH_LF);
      end
      2: send_word(CMD_BYTE, CH_LF);
      3: send_word(CMD_BYTE, CH_CR);
      4: send_word(CMD_BYTE, CH_NUL);
      default: send_word(CMD_EOL, 8'h00);
    endcase
  endtask

  // Every field class, empty fields, quote handling and a CR LF pair.
  task automatic test_classes_and_quotes();
    send_text("-1,.5,,\"a\"b");
    send_word(CMD_BYTE, CH_CR);
    send_word(CMD_BYTE, CH_LF);
  endtask

  // Lone minus, top byte value, closed quote at line end, table clear, empty line.
  task automatic test_line_ends();
    send_text("-,");
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_EOL, 8'hFF);
    send_text("\"9\"");
    send_word(CMD_EOL, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_NOP, 8'hFF);
    send_word(CMD_BYTE, CH_NUL);
  endtask

  // No fields taken, then the limit lowered in the middle of a line.
  task automatic test_field_limit();
    write_limit(7'd0);
    send_text("x");
    send_word(CMD_BYTE, CH_LF);
    write_limit(7'd64);
    send_text("p,q");
    write_limit(7'd1);
    send_text("r,s");
    send_word(CMD_BYTE, CH_LF);
  endtask

  // Random lines under one idling pattern, with the limit changed now and then.
  task automatic test_random_phase(int unsigned n_words, int unsigned src_pct,
                                   int unsigned sink_pct, logic [CNT_W-1:0] first_limit);
    int unsigned stop_at;
    int unsigned n_lines;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    write_limit(first_limit);
    stop_at = words_sent + n_words;
    n_lines = 0;
    while (words_sent < stop_at) begin
      send_random_line();
      n_lines++;
      if (n_lines % 10 == 0) write_limit(pick_limit());
    end
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_BYTE;
    in_if.ch     = 8'h00;
    out_if.ready = 1'b0;
    foreach (col_widest[i]) col_widest[i] = CLS_EMPTY;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_classes_and_quotes();
    test_line_ends();
    test_field_limit();
    test_random_phase(300, 25, 78, 7'd127);
    test_random_phase(300, 78, 25, 7'd3);
    test_random_phase(300, 0, 0, 7'd64);

    // Drain the result channel.
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (split_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d input words in directed cases and three random idling phases.",
             words_sent);
    $display("Checked %0d result words across %0d lines, with %0d field limit writes.",
             words_checked, lines_checked, limit_writes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/csvfs_pkg.sv
rtl/csvfs_intf.sv
rtl/csvfs_front.sv
rtl/csvfs_queue.sv
rtl/csvfs_back.sv
rtl/csv_field_splitter_type_classifier_core.sv
test/tb_top.sv
